[rtl/i2c_master_register_write_core_defines.svh]
`ifndef I2C_MASTER_REGISTER_WRITE_CORE_DEFINES_SVH
`define I2C_MASTER_REGISTER_WRITE_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define I2CW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cw assertion failed");

// next-cycle implication, checked while out of reset
`define I2CW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cw assertion failed");

`endif

[rtl/i2cw_pkg.sv]
package i2cw_pkg;

    localparam int TICKS_PER_US = 50;

    localparam logic [7:0] LEN_ONE    = 8'd1;
    localparam logic [7:0] SETUP_LOW  = 8'(TICKS_PER_US);
    localparam logic [7:0] HOLD_MED   = 8'(2 * TICKS_PER_US);
    localparam logic [7:0] HOLD_LOW   = 8'(5 * TICKS_PER_US);

    localparam logic [1:0] SPEED_HIGH   = 2'd0;
    localparam logic [1:0] SPEED_MEDIUM = 2'd1;
    localparam logic [1:0] SPEED_LOW    = 2'd2;

    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_SPEED_MODE     = 2'd1;

    localparam logic [1:0] BYTE_FIRST = 2'd0;
    localparam logic [1:0] BYTE_REG   = 2'd1;
    localparam logic [1:0] BYTE_LAST  = 2'd2;
    localparam logic [1:0] BYTE_ABORT = 2'd3;
    localparam logic [2:0] BIT_LAST   = 3'd7;

    typedef enum logic [9:0] {
        PH_IDLE        = 10'b00_0000_0001,
        PH_START_SETUP = 10'b00_0000_0010,
        PH_START_HOLD  = 10'b00_0000_0100,
        PH_BIT_SETUP   = 10'b00_0000_1000,
        PH_BIT_HIGH    = 10'b00_0001_0000,
        PH_ACK_SETUP   = 10'b00_0010_0000,
        PH_ACK_HIGH    = 10'b00_0100_0000,
        PH_STOP_SETUP  = 10'b00_1000_0000,
        PH_STOP_HOLD   = 10'b01_0000_0000,
        PH_DONE        = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic [1:0] speed_mode;
    } cfg_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic sda_drive;
        logic busy_res;
        logic done_res;
        logic status;
    } result_t;

    function automatic logic [7:0] setup_len(input logic [1:0] speed);
        logic [7:0] len;
        len = SETUP_LOW;
        if (speed == SPEED_HIGH || speed == SPEED_MEDIUM)
        begin
            len = LEN_ONE;
        end
        return len;
    endfunction

    function automatic logic [7:0] hold_len(input logic [1:0] speed);
        logic [7:0] len;
        len = HOLD_LOW;
        if (speed == SPEED_HIGH)
        begin
            len = LEN_ONE;
        end
        else if (speed == SPEED_MEDIUM)
        begin
            len = HOLD_MED;
        end
        return len;
    endfunction

endpackage

[rtl/i2cw_seq.sv]
module i2cw_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              start_request,
    input  logic [7:0]        reg_address,
    input  logic [7:0]        write_data,
    input  logic              check_ack,
    input  logic              sda_sample,
    input  i2cw_pkg::cfg_t    cfg,
    output i2cw_pkg::result_t result
);
    import i2cw_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] byte_index_reg, byte_index_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] held_reg_address_reg, held_reg_address_next;
    logic [7:0] held_data_reg, held_data_next;
    logic       held_check_reg, held_check_next;

    logic       is_setup;
    logic [7:0] len;
    logic [8:0] tick_inc;
    logic       over;
    logic       tx_bit;

    assign tx_bit   = shift_byte_reg[7];
    assign is_setup = (phase_reg == PH_START_SETUP) || (phase_reg == PH_BIT_SETUP) ||
                      (phase_reg == PH_ACK_SETUP) || (phase_reg == PH_STOP_SETUP);
    assign len      = is_setup ? setup_len(cfg.speed_mode) : hold_len(cfg.speed_mode);
    assign tick_inc = {1'b0, tick_count_reg} + 9'd1;
    assign over     = tick_inc >= {1'b0, len};

    // pin levels follow the phase held before this tick
    always_comb
    begin
        result = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
                   busy_res: 1'b1, done_res: 1'b0, status: 1'b0};
        case (phase_reg)
            PH_START_SETUP: ;
            PH_START_HOLD:  result.sda_level = 1'b0;
            PH_BIT_SETUP:
            begin
                result.scl_level = 1'b0;
                result.sda_level = tx_bit;
            end
            PH_BIT_HIGH:    result.sda_level = tx_bit;
            PH_ACK_SETUP:
            begin
                result.scl_level = 1'b0;
                result.sda_drive = 1'b0;
            end
            PH_ACK_HIGH:    result.sda_drive = 1'b0;
            PH_STOP_SETUP:  result.sda_level = 1'b0;
            PH_STOP_HOLD:   ;
            PH_DONE:
            begin
                result.busy_res = 1'b0;
                result.done_res = 1'b1;
                result.status   = (byte_index_reg == BYTE_ABORT);
            end
            default:        result.busy_res = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next            = phase_reg;
        byte_index_next       = byte_index_reg;
        bit_index_next        = bit_index_reg;
        shift_byte_next       = shift_byte_reg;
        tick_count_next       = over ? 8'd0 : tick_inc[7:0];
        held_reg_address_next = held_reg_address_reg;
        held_data_next        = held_data_reg;
        held_check_next       = held_check_reg;
        case (phase_reg)
            PH_START_SETUP: if (over) phase_next = PH_START_HOLD;
            PH_START_HOLD:  if (over) phase_next = PH_BIT_SETUP;
            PH_BIT_SETUP:   if (over) phase_next = PH_BIT_HIGH;
            PH_BIT_HIGH:
            begin
                if (over)
                begin
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    if (bit_index_reg == BIT_LAST)
                    begin
                        bit_index_next = 3'd0;
                        phase_next     = PH_ACK_SETUP;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = PH_BIT_SETUP;
                    end
                end
            end
            PH_ACK_SETUP:   if (over) phase_next = PH_ACK_HIGH;
            PH_ACK_HIGH:
            begin
                if (over)
                begin
                    if (sda_sample && held_check_reg)
                    begin
                        byte_index_next = BYTE_ABORT;
                        phase_next      = PH_STOP_SETUP;
                    end
                    else if (byte_index_reg >= BYTE_LAST)
                    begin
                        phase_next = PH_STOP_SETUP;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 2'd1;
                        shift_byte_next = (byte_index_reg == BYTE_FIRST) ?
                                          held_reg_address_reg : held_data_reg;
                        bit_index_next  = 3'd0;
                        phase_next      = PH_BIT_SETUP;
                    end
                end
            end
            PH_STOP_SETUP:  if (over) phase_next = PH_STOP_HOLD;
            PH_STOP_HOLD:   if (over) phase_next = PH_DONE;
            default:
            begin
                tick_count_next = 8'd0;
                if (start_request)
                begin
                    held_reg_address_next = reg_address;
                    held_data_next        = write_data;
                    held_check_next       = check_ack;
                    shift_byte_next       = {cfg.device_address, 1'b0};
                    byte_index_next       = BYTE_FIRST;
                    bit_index_next        = 3'd0;
                    phase_next            = PH_START_SETUP;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            byte_index_reg       <= '0;
            bit_index_reg        <= '0;
            shift_byte_reg       <= '0;
            tick_count_reg       <= '0;
            held_reg_address_reg <= '0;
            held_data_reg        <= '0;
            held_check_reg       <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg            <= phase_next;
            byte_index_reg       <= byte_index_next;
            bit_index_reg        <= bit_index_next;
            shift_byte_reg       <= shift_byte_next;
            tick_count_reg       <= tick_count_next;
            held_reg_address_reg <= held_reg_address_next;
            held_data_reg        <= held_data_next;
            held_check_reg       <= held_check_next;
        end
    end

endmodule

[rtl/i2cw_out_buf.sv]
module i2cw_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  i2cw_pkg::result_t result_in,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output i2cw_pkg::result_t result_out
);
    import i2cw_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_load;

    assign out_load   = !out_valid_reg || !out_stall;
    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign result_out = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result_in;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

[rtl/i2c_master_register_write_core.sv]
// channel  handshake                  payload
// in       in_valid / in_stall        start_request reg_address write_data check_ack sda_sample
// out      out_valid / out_stall      scl_level sda_level sda_drive busy_res done_res status
// cfg      cfg_valid / cfg_ready      cfg_index cfg_data
//
// one transaction in, one transaction out; a new input every cycle while in_stall is low
// the result is registered in the output register, or held in the skid entry while out_stall holds it
// a two-entry output buffer keeps input flowing while a result waits
// reset: idle, speed_mode low, device_address zero; cfg_ready is always high
// input stalls only when both output entries are full
module i2c_master_register_write_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_request,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_data,
    input  logic       check_ack,
    input  logic       sda_sample,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic       status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);
    import i2cw_pkg::*;

    cfg_t    cfg_reg;
    result_t seq_result;
    result_t buf_result;
    logic    in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= 7'd0;
            cfg_reg.speed_mode     <= SPEED_LOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                CFG_SPEED_MODE:     cfg_reg.speed_mode     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    i2cw_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .start_request (start_request),
        .reg_address   (reg_address),
        .write_data    (write_data),
        .check_ack     (check_ack),
        .sda_sample    (sda_sample),
        .cfg           (cfg_reg),
        .result        (seq_result)
    );

    i2cw_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .result_in  (seq_result),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (buf_result)
    );

    assign scl_level = buf_result.scl_level;
    assign sda_level = buf_result.sda_level;
    assign sda_drive = buf_result.sda_drive;
    assign busy_res  = buf_result.busy_res;
    assign done_res  = buf_result.done_res;
    assign status    = buf_result.status;

endmodule

[rtl/i2cw_checker.sv]
`include "i2c_master_register_write_core_defines.svh"

module i2cw_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic scl_level,
    input logic sda_level,
    input logic sda_drive,
    input logic busy_res,
    input logic done_res,
    input logic status
);

    `I2CW_ASSERT_IMP(a_done_not_busy, out_valid && done_res, !busy_res)
    `I2CW_ASSERT_IMP(a_status_with_done, out_valid && status, done_res)
    `I2CW_ASSERT_IMP(a_release_only_busy, out_valid && !sda_drive, busy_res && sda_level)
    `I2CW_ASSERT_IMP(a_idle_lines_high, out_valid && !busy_res, scl_level && sda_level)
    `I2CW_ASSERT_NXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(scl_level))

endmodule

bind i2c_master_register_write_core i2cw_checker u_i2cw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .sda_drive (sda_drive),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .status    (status)
);
